### hw/rtl/tsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsd_pkg;

	// Widths of the fixed fields.
	localparam int RAW_W    = 8;
	localparam int NBITS_W  = 4;
	localparam int SKIP_W   = 3;
	localparam int LIMIT_W  = 9;
	localparam int COUNT_W  = 9;
	localparam int SYM_W    = 6;
	localparam int NIB_W    = 4;
	localparam int HOLD_W   = 5;
	localparam int WIDE_W   = HOLD_W + RAW_W;
	localparam int TOTAL_W  = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	// Depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_BITS    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT = 1'd1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

	// Frame status reported with the last byte.
	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_SYMBOL  = 3'd1,
		ST_BUFFER_FULL = 3'd2,
		ST_ODD_NIBBLE  = 3'd3,
		ST_EMPTY       = 3'd4
	} status_t;

	// Why decoding of the current frame has stopped.
	typedef enum logic [1:0] {
		STOP_RUN  = 2'd0,
		STOP_BAD  = 2'd1,
		STOP_FULL = 2'd2
	} stop_t;

	typedef struct packed {
		logic [RAW_W-1:0]   raw_byte;
		logic [NBITS_W-1:0] valid_bits;
		logic               frame_end;
	} item_t;

	typedef struct packed {
		logic [RAW_W-1:0]   decoded_byte;
		logic               byte_valid;
		logic               done_res;
		status_t            status;
		logic [COUNT_W-1:0] byte_count;
	} res_t;

	// Stream bits of one request after skipping, right aligned.
	typedef struct packed {
		logic [RAW_W-1:0]   bits;
		logic [NBITS_W-1:0] nbits;
		logic               last;
	} seg_t;

	// Decoded symbol: ok flag and nibble.
	typedef struct packed {
		logic             ok;
		logic [NIB_W-1:0] nib;
	} nib_t;

	// Inverse of the 3-of-6 code table.
	function automatic nib_t sym_decode(input logic [SYM_W-1:0] sym);
		nib_t r;
		r.ok = 1'b1;
		unique case (sym)
			6'h16: r.nib = 4'h0;
			6'h0D: r.nib = 4'h1;
			6'h0E: r.nib = 4'h2;
			6'h0B: r.nib = 4'h3;
			6'h1C: r.nib = 4'h4;
			6'h19: r.nib = 4'h5;
			6'h1A: r.nib = 4'h6;
			6'h13: r.nib = 4'h7;
			6'h2C: r.nib = 4'h8;
			6'h25: r.nib = 4'h9;
			6'h26: r.nib = 4'hA;
			6'h23: r.nib = 4'hB;
			6'h34: r.nib = 4'hC;
			6'h31: r.nib = 4'hD;
			6'h32: r.nib = 4'hE;
			6'h29: r.nib = 4'hF;
			default: begin
				r.ok  = 1'b0;
				r.nib = 4'h0;
			end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/tsd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tsd_front
	import tsd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              skip_we,
	input  wire logic [SKIP_W-1:0] skip_wdata,
	input  wire logic              accept,
	input  wire item_t             item,
	output seg_t                   seg
);

	logic [SKIP_W-1:0]  skip_bits_q;
	logic [SKIP_W-1:0]  skip_left_q;
	logic [NBITS_W-1:0] nv;
	logic [NBITS_W-1:0] skipped;
	logic [NBITS_W-1:0] kept;
	logic [RAW_W-1:0]   aligned;
	logic [RAW_W-1:0]   mask;

	// Clamp the bit count, drop the bits still to be skipped, right align the rest.
	always_comb begin
		nv = (item.valid_bits > NBITS_W'(RAW_W)) ? NBITS_W'(RAW_W) : item.valid_bits;
		skipped = ({1'b0, skip_left_q} < nv) ? {1'b0, skip_left_q} : nv;
		kept = nv - skipped;
		aligned = item.raw_byte >> (NBITS_W'(RAW_W) - nv);
		mask = RAW_W'((16'd1 << kept) - 16'd1);
		seg.bits = aligned & mask;
		seg.nbits = kept;
		seg.last = item.frame_end;
	end

	// Skip setting and the bits of it still left in this frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_bits_q <= '0;
			skip_left_q <= '0;
		end else if (skip_we) begin
			skip_bits_q <= skip_wdata;
			skip_left_q <= skip_wdata;
		end else if (accept) begin
			if (item.frame_end) begin
				skip_left_q <= skip_bits_q;
			end else begin
				skip_left_q <= skip_left_q - SKIP_W'(skipped);
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/tsd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tsd_queue
	import tsd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire seg_t wdata,
	output logic      full,
	output logic      empty,
	input  wire logic pop,
	output seg_t      rdata
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	seg_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = entry_q[rptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/tsd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tsd_back
	import tsd_pkg::*;
#(
	parameter int MAX_OUT_BYTES = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               limit_we,
	input  wire logic [LIMIT_W-1:0] limit_wdata,
	input  wire logic               seg_avail,
	input  wire seg_t               seg,
	output logic                    seg_pop,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output res_t                    res
);

	localparam int CW = $clog2(MAX_OUT_BYTES + 1);
	localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

	logic [LIMIT_W-1:0] limit_q;
	logic [HOLD_W-1:0]  buf_q;
	logic [2:0]         cnt_q;
	logic [NIB_W-1:0]   upper_q;
	logic               held_q;
	logic [CW-1:0]      emitted_q;
	stop_t              stop_q;
	logic               res_valid_q;
	res_t               res_q;

	logic [LW-1:0]      limit_eff;
	logic [WIDE_W-1:0]  wide;
	logic [TOTAL_W-1:0] total;
	logic [TOTAL_W-1:0] rem;
	logic [SYM_W-1:0]   sym [2];
	nib_t               dec;
	logic [HOLD_W-1:0]  buf_n;
	logic [2:0]         cnt_n;
	logic [NIB_W-1:0]   upper_n;
	logic               held_n;
	logic [CW-1:0]      emitted_n;
	stop_t              stop_n;
	res_t               res_n;

	assign seg_pop   = seg_avail && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Effective byte limit of a frame.
	assign limit_eff = (LW'(limit_q) > LW'(MAX_OUT_BYTES)) ? LW'(MAX_OUT_BYTES) : LW'(limit_q);

	// Append the new bits, cut up to two symbols, decode and pair them.
	always_comb begin
		wide  = (WIDE_W'(buf_q) << seg.nbits) | WIDE_W'(seg.bits);
		total = TOTAL_W'(cnt_q) + seg.nbits;
		sym[0] = SYM_W'(wide >> (total - TOTAL_W'(SYM_W)));
		sym[1] = SYM_W'(wide >> (total - TOTAL_W'(2 * SYM_W)));
		rem       = total;
		upper_n   = upper_q;
		held_n    = held_q;
		emitted_n = emitted_q;
		stop_n    = stop_q;
		res_n     = '0;
		res_n.status = ST_OK;
		dec       = '0;
		for (int i = 0; i < 2; i++) begin
			if (stop_n == STOP_RUN && total >= TOTAL_W'((i + 1) * SYM_W)) begin
				rem = total - TOTAL_W'((i + 1) * SYM_W);
				dec = sym_decode(sym[i]);
				if (!dec.ok) begin
					stop_n = STOP_BAD;
				end else if (!held_n) begin
					upper_n = dec.nib;
					held_n  = 1'b1;
				end else if (LW'(emitted_n) >= limit_eff) begin
					stop_n = STOP_FULL;
				end else begin
					res_n.decoded_byte = {upper_n, dec.nib};
					res_n.byte_valid   = 1'b1;
					emitted_n = emitted_n + 1'b1;
					held_n    = 1'b0;
				end
			end
		end

		// A stopped frame keeps its bit store untouched.
		if (stop_q == STOP_RUN) begin
			buf_n = HOLD_W'(wide & WIDE_W'((16'd1 << rem) - 16'd1));
			cnt_n = 3'(rem);
		end else begin
			buf_n = buf_q;
			cnt_n = cnt_q;
		end

		// Frame end reports status and count, then clears the frame state.
		if (seg.last) begin
			res_n.done_res = 1'b1;
			priority if (stop_n == STOP_BAD) begin
				res_n.status = ST_BAD_SYMBOL;
			end else if (stop_n == STOP_FULL) begin
				res_n.status = ST_BUFFER_FULL;
			end else if (held_n) begin
				res_n.status = ST_ODD_NIBBLE;
			end else if (emitted_n == '0) begin
				res_n.status = ST_EMPTY;
			end else begin
				res_n.status = ST_OK;
			end
			res_n.byte_count = COUNT_W'(emitted_n);
			buf_n     = '0;
			cnt_n     = '0;
			upper_n   = '0;
			held_n    = 1'b0;
			emitted_n = '0;
			stop_n    = STOP_RUN;
		end
	end

	// Frame state, limit register and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			buf_q       <= '0;
			cnt_q       <= '0;
			upper_q     <= '0;
			held_q      <= 1'b0;
			emitted_q   <= '0;
			stop_q      <= STOP_RUN;
			res_valid_q <= 1'b0;
		end else begin
			if (limit_we) begin
				limit_q <= limit_wdata;
			end
			if (seg_pop) begin
				buf_q     <= buf_n;
				cnt_q     <= cnt_n;
				upper_q   <= upper_n;
				held_q    <= held_n;
				emitted_q <= emitted_n;
				stop_q    <= stop_n;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (seg_pop) begin
			res_q <= res_n;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/three_of_six_stream_decoder.sv
// Streaming 3-of-6 decoder for encoded radio frame bytes.
// Requests arrive on item (valid/ready): one encoded byte, the number of its
// leading bits that belong to the stream, and a frame end flag. Each request
// gives exactly one response on res (valid/ready): a decoded byte when one
// was completed, and on the frame's last byte the status and byte count.
// A response becomes valid once its request has passed through the queue and
// been registered in the back stage's output register.
// Throughput: one request per cycle; a front stage aligns the bits and a
// back stage decodes up to two symbols per request from a small table.
// A two-entry queue sits between them, and the output is registered, so the
// block keeps taking requests while a response waits; once the receiver has
// stalled long enough to fill the queue, item_ready drops until it drains.
// Configuration: cfg_we with cfg_index selects skip bits (0) or the output
// byte limit (1); write only while no request is outstanding.
// Reset clears all frame state, sets skip bits to 0 and the limit to 256.
`timescale 1ns / 1ps
`default_nettype none

module three_of_six_stream_decoder
	import tsd_pkg::*;
#(
	parameter int MAX_OUT_BYTES = 256
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire item_t                 item,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output res_t                       res,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic accept;
	logic skip_we;
	logic limit_we;
	logic q_full;
	logic q_empty;
	logic q_pop;
	seg_t seg_in;
	seg_t seg_out;

	// Register write decode.
	assign skip_we  = cfg_we && (cfg_index == CFG_SKIP_BITS);
	assign limit_we = cfg_we && (cfg_index == CFG_OUTPUT_LIMIT);

	// Requests are taken while the queue has room.
	assign item_ready = !q_full;
	assign accept     = item_valid && !q_full;

	tsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.skip_we    (skip_we),
		.skip_wdata (cfg_wdata[SKIP_W-1:0]),
		.accept     (accept),
		.item       (item),
		.seg        (seg_in)
	);

	tsd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (seg_in),
		.full   (q_full),
		.empty  (q_empty),
		.pop    (q_pop),
		.rdata  (seg_out)
	);

	tsd_back #(
		.MAX_OUT_BYTES (MAX_OUT_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.limit_we    (limit_we),
		.limit_wdata (cfg_wdata[LIMIT_W-1:0]),
		.seg_avail   (!q_empty),
		.seg         (seg_out),
		.seg_pop     (q_pop),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

endmodule

`default_nettype wire

### dv/tsd_decode_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the decoder, predicts the response of every
// accepted request and compares it with what the block returns.
module tsd_decode_checker
	import tsd_pkg::*;
#(
	parameter int MAX_OUT_BYTES = 256
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	input  wire logic                  item_ready,
	input  wire item_t                 item,
	input  wire logic                  res_valid,
	input  wire logic                  res_ready,
	input  wire res_t                  res,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                         fail_count,
	output int                         outstanding,
	output int                         checked
);

	// Code words of the 3-of-6 table, nibble 0 in the lowest six bits.
	localparam logic [95:0] CODE_WORDS = {
		6'h29, 6'h32, 6'h31, 6'h34, 6'h23, 6'h26, 6'h25, 6'h2C,
		6'h13, 6'h1A, 6'h19, 6'h1C, 6'h0B, 6'h0E, 6'h0D, 6'h16
	};

	// Register copies.
	int skip_setting;
	int limit_setting;

	// Frame state of the predictor.
	int    bit_store;
	int    bits_held;
	int    skip_pending;
	int    upper_nib;
	bit    high_pending;
	int    emitted;
	stop_t halt;

	// Responses predicted for accepted requests, oldest first.
	res_t pending_decodes[$];

	function automatic int nibble_of(input int sym);
		for (int n = 0; n < 16; n++) begin
			if (CODE_WORDS[6*n +: 6] == sym[5:0]) return n;
		end
		return -1;
	endfunction

	task automatic clear_frame();
		bit_store    = 0;
		bits_held    = 0;
		skip_pending = skip_setting;
		upper_nib    = 0;
		high_pending = 1'b0;
		emitted      = 0;
		halt         = STOP_RUN;
	endtask

	// Appends the stream bits of one request, decodes every complete symbol
	// and closes the frame when the request carries its end.
	task automatic decode_request(input item_t req, output res_t expected);
		int nbits;
		int taken;
		int fresh;
		int lim;
		int sym;
		int nib;
		expected        = '0;
		expected.status = ST_OK;
		nbits = (req.valid_bits > 8) ? 8 : int'(req.valid_bits);
		lim   = (limit_setting > MAX_OUT_BYTES) ? MAX_OUT_BYTES : limit_setting;
		if (halt == STOP_RUN) begin
			fresh        = int'(req.raw_byte) >> (8 - nbits);
			taken        = (skip_pending < nbits) ? skip_pending : nbits;
			skip_pending = skip_pending - taken;
			nbits        = nbits - taken;
			fresh        = fresh & ((1 << nbits) - 1);
			bit_store    = ((bit_store << nbits) | fresh) & 16'hFFFF;
			bits_held    = bits_held + nbits;
			while (bits_held >= 6 && halt == STOP_RUN) begin
				sym       = (bit_store >> (bits_held - 6)) & 6'h3F;
				bits_held = bits_held - 6;
				bit_store = bit_store & ((1 << bits_held) - 1);
				nib       = nibble_of(sym);
				if (nib < 0) begin
					halt = STOP_BAD;
				end else if (!high_pending) begin
					upper_nib    = nib;
					high_pending = 1'b1;
				end else if (emitted >= lim) begin
					// The high nibble stays held once the limit is hit.
					halt = STOP_FULL;
				end else begin
					expected.decoded_byte = 8'((upper_nib << 4) | nib);
					expected.byte_valid   = 1'b1;
					emitted++;
					high_pending = 1'b0;
				end
			end
		end
		if (req.frame_end) begin
			expected.done_res = 1'b1;
			if (halt == STOP_BAD) expected.status = ST_BAD_SYMBOL;
			else if (halt == STOP_FULL) expected.status = ST_BUFFER_FULL;
			else if (high_pending) expected.status = ST_ODD_NIBBLE;
			else if (emitted == 0) expected.status = ST_EMPTY;
			expected.byte_count = emitted[COUNT_W-1:0];
			clear_frame();
		end
	endtask

	task automatic flag(input string what, input int got, input int want);
		fail_count++;
		$display("[%0t ns] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	task automatic compare_response(input res_t got, input res_t want);
		if (got.decoded_byte !== want.decoded_byte)
			flag("decoded_byte", int'(got.decoded_byte), int'(want.decoded_byte));
		if (got.byte_valid !== want.byte_valid)
			flag("byte_valid", int'(got.byte_valid), int'(want.byte_valid));
		if (got.done_res !== want.done_res)
			flag("done_res", int'(got.done_res), int'(want.done_res));
		if (got.status !== want.status)
			flag("status", int'(got.status), int'(want.status));
		if (got.byte_count !== want.byte_count)
			flag("byte_count", int'(got.byte_count), int'(want.byte_count));
	endtask

	// Responses are checked before the predictor sees a new request, since a
	// response never belongs to the request accepted at the same edge.
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			skip_setting  = 0;
			limit_setting = int'(LIMIT_RESET);
			clear_frame();
			pending_decodes.delete();
		end else begin
			if (res_valid && res_ready) begin
				if (pending_decodes.size() == 0) begin
					flag("response with no request waiting", 1, 0);
				end else begin
					want = pending_decodes.pop_front();
					compare_response(res, want);
					checked++;
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_SKIP_BITS) begin
					skip_setting = int'(cfg_wdata[SKIP_W-1:0]);
					skip_pending = skip_setting;
				end else if (cfg_index == CFG_OUTPUT_LIMIT) begin
					limit_setting = int'(cfg_wdata);
				end
			end
			if (item_valid && item_ready) begin
				decode_request(item, want);
				pending_decodes.push_back(want);
			end
		end
		outstanding = pending_decodes.size();
	end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import tsd_pkg::*;

	localparam int MAX_BYTES          = 256;
	localparam int ITEM_TARGET        = 1100;
	localparam int FRAMES_PER_SETTING = 6;

	// Code words of the 3-of-6 table, nibble 0 in the lowest six bits.
	localparam logic [95:0] CODE_WORDS = {
		6'h29, 6'h32, 6'h31, 6'h34, 6'h23, 6'h26, 6'h25, 6'h2C,
		6'h13, 6'h1A, 6'h19, 6'h1C, 6'h0B, 6'h0E, 6'h0D, 6'h16
	};

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_ready;
	item_t                 item       = '0;
	logic                  res_valid;
	logic                  res_ready  = 1'b0;
	res_t                  res;
	logic                  cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = CFG_SKIP_BITS;
	logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

	int fail_count;
	int outstanding;
	int checked;
	int n_sent     = 0;
	int n_frames   = 0;
	int n_settings = 0;
	int cur_skip   = 0;
	int ready_hold = 0;
	bit calm       = 1'b0;

	three_of_six_stream_decoder #(
		.MAX_OUT_BYTES(MAX_BYTES)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	tsd_decode_checker #(
		.MAX_OUT_BYTES(MAX_BYTES)
	) decode_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.checked     (checked)
	);

	always #5 clk = ~clk;

	// Mostly no pause, sometimes a few cycles, rarely a long one.
	function automatic int pause_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int pick_limit();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 15) return $urandom_range(0, 3);
		if (roll < 55) return $urandom_range(4, 24);
		if (roll < 85) return int'(LIMIT_RESET);
		return $urandom_range(257, 511);
	endfunction

	function automatic int bad_symbol();
		int sym;
		bit known;
		do begin
			sym   = $urandom_range(0, 63);
			known = 1'b0;
			for (int n = 0; n < 16; n++) begin
				if (CODE_WORDS[6*n +: 6] == sym[5:0]) known = 1'b1;
			end
		end while (known);
		return sym;
	endfunction

	// Receiver side: random stalls, always ready during calm stretches.
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
		end else begin
			res_ready <= calm || ($urandom_range(0, 3) != 0);
			ready_hold = pause_len();
		end
	end

	// Offers one request and returns at the falling edge after it is taken.
	// Valid is only lowered when a gap follows, so back-to-back requests keep
	// it high.
	task automatic push_item(input item_t req);
		int gap;
		gap = calm ? 0 : pause_len();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item       <= req;
		item_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!item_ready);
		@(negedge clk);
		n_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Drains all responses, then writes both registers.
	task automatic configure(input int skip, input int limit);
		item_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		write_reg(CFG_SKIP_BITS, skip);
		write_reg(CFG_OUTPUT_LIMIT, limit);
		cur_skip = skip;
		n_settings++;
	endtask

	// Encodes the nibbles into a bit stream behind the skipped bits, with one
	// symbol optionally replaced by an invalid one and some trailing bits,
	// and cuts it into requests. Chopping adds short bytes inside the frame,
	// bytes with no stream bits, and bit counts above eight on full bytes.
	task automatic send_frame(input int nibs[$], input int bad_at, input int tail,
			input bit chop);
		bit    stream[$];
		item_t req;
		int    sym;
		int    take;
		repeat (cur_skip) stream.push_back(1'($urandom_range(0, 1)));
		foreach (nibs[i]) begin
			sym = CODE_WORDS[6*nibs[i] +: 6];
			if (i == bad_at) sym = bad_symbol();
			for (int b = 5; b >= 0; b--) stream.push_back(sym[b]);
		end
		repeat (tail) stream.push_back(1'($urandom_range(0, 1)));
		if (stream.size() == 0) begin
			req.raw_byte   = RAW_W'($urandom_range(0, 255));
			req.valid_bits = '0;
			req.frame_end  = 1'b1;
			push_item(req);
		end
		while (stream.size() > 0) begin
			if (chop && $urandom_range(0, 7) == 0) begin
				req.raw_byte   = RAW_W'($urandom_range(0, 255));
				req.valid_bits = '0;
				req.frame_end  = 1'b0;
				push_item(req);
			end
			take = (chop && $urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 8;
			if (take > stream.size()) take = stream.size();
			req.raw_byte = RAW_W'($urandom_range(0, 255));
			for (int b = 7; b > 7 - take; b--) req.raw_byte[b] = stream.pop_front();
			req.valid_bits = NBITS_W'(take);
			if (take == 8 && chop && $urandom_range(0, 3) == 0)
				req.valid_bits = NBITS_W'($urandom_range(9, 15));
			req.frame_end = (stream.size() == 0);
			push_item(req);
		end
		n_frames++;
	endtask

	task automatic random_frame(input int n_nib, input int bad_at, input int tail,
			input bit chop);
		int nibs[$];
		repeat (n_nib) nibs.push_back($urandom_range(0, 15));
		send_frame(nibs, bad_at, tail, chop);
	endtask

	// Unstructured bytes with any bit count.
	task automatic send_noise(input int len);
		item_t req;
		for (int k = 0; k < len; k++) begin
			req.raw_byte   = RAW_W'($urandom_range(0, 255));
			req.valid_bits = NBITS_W'($urandom_range(0, 15));
			req.frame_end  = (k == len - 1);
			push_item(req);
		end
		n_frames++;
	endtask

	initial begin
		int nibs[$];
		int roll;
		int n_nib;
		int bad;
		int wait_left;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames at the reset settings.
		nibs = '{0, 15};
		send_frame(nibs, -1, 0, 1'b0);
		// A request with no stream bits ends an empty frame.
		push_item({8'h00, 4'h0, 1'b1});
		// All ones with a bit count above eight is an invalid symbol.
		push_item({8'hFF, 4'hF, 1'b1});
		// All zeros is an invalid symbol as well.
		push_item({8'h00, 4'h8, 1'b1});
		nibs = '{1, 2, 3};
		send_frame(nibs, -1, 0, 1'b0);
		nibs = '{4, 5, 6, 7};
		send_frame(nibs, 2, 3, 1'b0);
		nibs = '{8, 9, 10, 11};
		send_frame(nibs, -1, 5, 1'b1);
		// Too short for a single symbol.
		nibs = {};
		send_frame(nibs, -1, 5, 1'b0);
		// Limit of one: the bad symbol completes the pair beyond the limit.
		configure(7, 1);
		nibs = '{12, 13, 14, 15};
		send_frame(nibs, 3, 0, 1'b0);
		// Limit of zero: the first pair already overflows.
		configure(0, 0);
		nibs = '{15, 15};
		send_frame(nibs, -1, 0, 1'b0);

		// One long frame that runs into the saturated limit.
		configure(3, 511);
		random_frame(528, -1, 0, 1'b0);

		// Random settings, mostly well-formed frames with random content.
		while (n_sent < ITEM_TARGET) begin
			configure($urandom_range(0, 7), pick_limit());
			calm = ($urandom_range(0, 3) == 0);
			repeat (FRAMES_PER_SETTING) begin
				roll = $urandom_range(0, 99);
				if (roll < 10) begin
					send_noise($urandom_range(1, 6));
				end else begin
					n_nib = $urandom_range(0, 24);
					bad   = (roll < 25) ? int'($urandom_range(0, n_nib)) : -1;
					random_frame(n_nib, bad, $urandom_range(0, 5),
						1'($urandom_range(0, 1)));
				end
			end
			calm = 1'b0;
		end

		// Drain, then allow a few more cycles for anything stray.
		item_valid <= 1'b0;
		wait_left = 100000;
		while (outstanding != 0 && wait_left > 0) begin
			@(negedge clk);
			wait_left--;
		end
		repeat (10) @(negedge clk);
		$display("Run covered %0d requests in %0d frames over %0d register settings.",
			n_sent, n_frames, n_settings);
		$display("%0d responses compared, %0d mismatches, %0d responses missing.",
			checked, fail_count, outstanding);
		if (fail_count == 0 && outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#20_000_000;
		$display("Timeout with %0d responses still outstanding.", outstanding);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
